// ----- hdl/drt_pkg.sv -----
// Shared types, codes and helpers for the downlink route table.
// Used by drt_cell and downlink_route_table; depends on nothing.
package drt_pkg;

    localparam logic [6:0] QUALITY_MAX = 7'd100;

    localparam logic [1:0] ACT_UPSERT     = 2'd0;
    localparam logic [1:0] ACT_LOOKUP     = 2'd1;
    localparam logic [1:0] ACT_INVALIDATE = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_MALFORMED = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    localparam logic REG_NODE_ID      = 1'b0;
    localparam logic REG_BROADCAST_ID = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // One stored route, without its key.
    typedef struct packed {
        logic [63:0] next_hop;
        logic [63:0] gateway;
        logic [31:0] epoch;
        logic [31:0] seen_time;
        logic [7:0]  hops;
        logic [6:0]  quality;
    } route_t;

    // Scan result handed from cell to cell.
    typedef struct packed {
        logic   match_hit;
        logic   free_hit;
        logic   worst_hit;
        route_t match_rec;
        route_t worst_rec;
    } carry_t;

    // Clamp both qualities to 100; a zero means unknown.
    function automatic logic [6:0] mix_quality(input logic [7:0] adv, input logic [7:0] lnk);
        logic [6:0] a;
        logic [6:0] l;
        logic [6:0] res;
        a = (adv > 8'(QUALITY_MAX)) ? QUALITY_MAX : adv[6:0];
        l = (lnk > 8'(QUALITY_MAX)) ? QUALITY_MAX : lnk[6:0];
        if (l == 7'd0) begin
            res = a;
        end else if (a == 7'd0) begin
            res = l;
        end else begin
            res = (a < l) ? a : l;
        end
        return res;
    endfunction

    // True when route a is better than route b.
    function automatic logic beats(input route_t a, input route_t b);
        logic res;
        if (a.epoch != b.epoch) begin
            res = a.epoch > b.epoch;
        end else if (a.hops != b.hops) begin
            res = a.hops < b.hops;
        end else if (a.quality != b.quality) begin
            res = a.quality > b.quality;
        end else if (a.seen_time != b.seen_time) begin
            res = a.seen_time > b.seen_time;
        end else begin
            res = a.next_hop < b.next_hop;
        end
        return res;
    endfunction

endpackage

// ----- hdl/drt_cell.sv -----
// One table slot: holds a route and folds it into the scan carry.
// Depends on drt_pkg.
module drt_cell #(
    parameter int CELL_IDX = 0,
    parameter int IW       = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [63:0]        req_target,
    input  drt_pkg::carry_t    carry_in,
    input  logic [IW-1:0]      match_idx_in,
    input  logic [IW-1:0]      free_idx_in,
    input  logic [IW-1:0]      worst_idx_in,
    output drt_pkg::carry_t    carry_out,
    output logic [IW-1:0]      match_idx_out,
    output logic [IW-1:0]      free_idx_out,
    output logic [IW-1:0]      worst_idx_out,
    input  logic               wr_en,
    input  logic               clr_en,
    input  logic [63:0]        wr_target,
    input  drt_pkg::route_t    wr_rec
);

    logic            valid_reg;
    logic [63:0]     target_reg;
    drt_pkg::route_t rec_reg;

    drt_pkg::carry_t carry_reg;
    drt_pkg::carry_t carry_next;
    logic [IW-1:0]   match_idx_reg;
    logic [IW-1:0]   match_idx_next;
    logic [IW-1:0]   free_idx_reg;
    logic [IW-1:0]   free_idx_next;
    logic [IW-1:0]   worst_idx_reg;
    logic [IW-1:0]   worst_idx_next;

    // Hold the entry; write or drop it on request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr_en) begin
            valid_reg <= 1'b1;
        end else if (clr_en) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            target_reg <= wr_target;
            rec_reg    <= wr_rec;
        end
    end

    // Fold this slot into the carry: first match, first free, worst valid.
    always_comb begin
        carry_next     = carry_in;
        match_idx_next = match_idx_in;
        free_idx_next  = free_idx_in;
        worst_idx_next = worst_idx_in;
        if (!carry_in.match_hit && valid_reg && target_reg == req_target) begin
            carry_next.match_hit = 1'b1;
            carry_next.match_rec = rec_reg;
            match_idx_next       = IW'(CELL_IDX);
        end
        if (!carry_in.free_hit && !valid_reg) begin
            carry_next.free_hit = 1'b1;
            free_idx_next       = IW'(CELL_IDX);
        end
        if (valid_reg && (!carry_in.worst_hit ||
                          drt_pkg::beats(carry_in.worst_rec, rec_reg))) begin
            carry_next.worst_hit = 1'b1;
            carry_next.worst_rec = rec_reg;
            worst_idx_next       = IW'(CELL_IDX);
        end
    end

    // Advance the carry to the next cell.
    always_ff @(posedge aclk) begin
        carry_reg     <= carry_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        worst_idx_reg <= worst_idx_next;
    end

    assign carry_out     = carry_reg;
    assign match_idx_out = match_idx_reg;
    assign free_idx_out  = free_idx_reg;
    assign worst_idx_out = worst_idx_reg;

endmodule

// ----- hdl/downlink_route_table.sv -----
// A request is scanned through the cell chain (ST_SCAN), then the table is updated and the result
// loaded in ST_DONE; m_ready low while a result is still held keeps the control in ST_DONE.
// A new request is taken only in ST_IDLE, after the previous one has left ST_DONE.
// Reset (aresetn low, synchronous) clears all valid bits, node id to 0, broadcast id to all ones.
// Top level of the downlink route table: APB registers, control and the cell row.
// Depends on drt_pkg and drt_cell.
module downlink_route_table #(
    parameter int ROUTE_ENTRIES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [63:0] s_target_id,
    input  logic [63:0] s_next_hop_id,
    input  logic [63:0] s_gateway_id,
    input  logic [31:0] s_route_epoch,
    input  logic [31:0] s_seen_time_ms,
    input  logic [7:0]  s_hop_count,
    input  logic [7:0]  s_advertised_quality,
    input  logic [7:0]  s_link_quality,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_found_next_hop,
    output logic [63:0] m_found_gateway,
    output logic [31:0] m_found_epoch,
    output logic [31:0] m_found_seen_time,
    output logic [7:0]  m_found_hops,
    output logic [6:0]  m_found_quality
);

    localparam int IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

    logic [63:0] node_id_reg;
    logic [63:0] broadcast_id_reg;

    drt_pkg::state_t state_reg;
    drt_pkg::state_t state_next;
    logic [IW-1:0]   cnt_reg;
    logic [IW-1:0]   cnt_next;

    logic [1:0]      act_reg;
    logic [63:0]     tgt_reg;
    drt_pkg::route_t new_reg;

    logic            m_valid_reg;
    logic            m_valid_next;
    logic [1:0]      status_reg;
    drt_pkg::route_t out_reg;
    logic            load_out;
    logic [1:0]      status_next;
    drt_pkg::route_t out_next;

    logic [ROUTE_ENTRIES-1:0] wr_vec;
    logic [ROUTE_ENTRIES-1:0] clr_vec;

    drt_pkg::carry_t carry   [ROUTE_ENTRIES+1];
    logic [IW-1:0]   m_idx   [ROUTE_ENTRIES+1];
    logic [IW-1:0]   f_idx   [ROUTE_ENTRIES+1];
    logic [IW-1:0]   w_idx   [ROUTE_ENTRIES+1];

    drt_pkg::carry_t fin;
    logic            bad_upsert;

    // Register file writes and reads.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg      <= '0;
            broadcast_id_reg <= '1;
        end else if (psel && penable && pwrite) begin
            if (paddr[3] == drt_pkg::REG_NODE_ID) begin
                node_id_reg <= pwdata;
            end else begin
                broadcast_id_reg <= pwdata;
            end
        end
    end

    assign prdata = (paddr[3] == drt_pkg::REG_BROADCAST_ID) ? broadcast_id_reg : node_id_reg;

    // Capture the request.
    assign s_ready = (state_reg == drt_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg           <= s_action;
            tgt_reg           <= s_target_id;
            new_reg.next_hop  <= s_next_hop_id;
            new_reg.gateway   <= s_gateway_id;
            new_reg.epoch     <= s_route_epoch;
            new_reg.seen_time <= s_seen_time_ms;
            new_reg.hops      <= s_hop_count;
            new_reg.quality   <= drt_pkg::mix_quality(s_advertised_quality, s_link_quality);
        end
    end

    // Cell row; the carry enters empty at the head.
    assign carry[0] = '0;
    assign m_idx[0] = '0;
    assign f_idx[0] = '0;
    assign w_idx[0] = '0;

    for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
        drt_cell #(
            .CELL_IDX (i),
            .IW       (IW)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .req_target    (tgt_reg),
            .carry_in      (carry[i]),
            .match_idx_in  (m_idx[i]),
            .free_idx_in   (f_idx[i]),
            .worst_idx_in  (w_idx[i]),
            .carry_out     (carry[i+1]),
            .match_idx_out (m_idx[i+1]),
            .free_idx_out  (f_idx[i+1]),
            .worst_idx_out (w_idx[i+1]),
            .wr_en         (wr_vec[i]),
            .clr_en        (clr_vec[i]),
            .wr_target     (tgt_reg),
            .wr_rec        (new_reg)
        );
    end

    assign fin        = carry[ROUTE_ENTRIES];
    assign bad_upsert = (tgt_reg == broadcast_id_reg) || (new_reg.next_hop == broadcast_id_reg) ||
                        (new_reg.gateway == broadcast_id_reg) || (tgt_reg == node_id_reg);

    // Sequence the scan and decide the table update and the result.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        wr_vec       = '0;
        clr_vec      = '0;
        load_out     = 1'b0;
        status_next  = drt_pkg::STAT_OK;
        out_next     = '0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            drt_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    state_next = drt_pkg::ST_SCAN;
                end
            end
            drt_pkg::ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IW'(ROUTE_ENTRIES - 1)) begin
                    state_next = drt_pkg::ST_DONE;
                end
            end
            drt_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = drt_pkg::ST_IDLE;
                    case (act_reg)
                        drt_pkg::ACT_UPSERT: begin
                            if (bad_upsert) begin
                                status_next = drt_pkg::STAT_MALFORMED;
                            end else if (fin.match_hit) begin
                                if (drt_pkg::beats(new_reg, fin.match_rec)) begin
                                    wr_vec[m_idx[ROUTE_ENTRIES]] = 1'b1;
                                end
                            end else if (fin.free_hit) begin
                                wr_vec[f_idx[ROUTE_ENTRIES]] = 1'b1;
                            end else begin
                                wr_vec[w_idx[ROUTE_ENTRIES]] = 1'b1;
                            end
                        end
                        drt_pkg::ACT_LOOKUP: begin
                            if (fin.match_hit && tgt_reg != broadcast_id_reg) begin
                                out_next = fin.match_rec;
                            end else begin
                                status_next = drt_pkg::STAT_NOT_FOUND;
                            end
                        end
                        drt_pkg::ACT_INVALIDATE: begin
                            if (fin.match_hit) begin
                                clr_vec[m_idx[ROUTE_ENTRIES]] = 1'b1;
                            end
                        end
                        default: begin
                            status_next = drt_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            default: begin
                state_next = drt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= drt_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the result until it is taken.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            status_reg <= status_next;
            out_reg    <= out_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_found_next_hop  = out_reg.next_hop;
    assign m_found_gateway   = out_reg.gateway;
    assign m_found_epoch     = out_reg.epoch;
    assign m_found_seen_time = out_reg.seen_time;
    assign m_found_hops      = out_reg.hops;
    assign m_found_quality   = out_reg.quality;

`ifndef SYNTH
    // At most one slot changes per request.
    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(wr_vec | clr_vec))
        else $error("more than one slot updated");

    // A new result only follows the update cycle.
    a_result_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> state_reg == drt_pkg::ST_DONE)
        else $error("result loaded outside update");

    // Table changes only in the update cycle.
    a_write_in_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (|(wr_vec | clr_vec)) |-> load_out)
        else $error("table written outside update");

    // The scan leaves the idle state only on a request.
    a_scan_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == drt_pkg::ST_IDLE && state_next == drt_pkg::ST_SCAN) |-> s_valid)
        else $error("scan started without request");
`endif

endmodule
